// ===== sv/hfc_pkg.sv =====
package hfc_pkg;

  localparam logic CmdF32ToF16 = 1'b0;
  localparam logic CmdF16ToF32 = 1'b1;

  localparam logic [7:0] ExpBiasDiff = 8'd112;

  typedef struct packed {
    logic        cmd;
    logic [31:0] op;
  } item_t;

endpackage

// ===== sv/hfc_f2h.sv =====
module hfc_f2h (
  input  logic [31:0] x_i,
  output logic [15:0] h_o
);

  logic        sgn;
  logic [7:0]  rexp;
  logic [22:0] man;
  logic [24:0] sig;
  logic [4:0]  drop;
  logic [24:0] kept;
  logic [24:0] rest;
  logic [24:0] halfw;
  logic [24:0] rmask;
  logic [10:0] sub_r;
  logic [9:0]  nkept;
  logic [12:0] nrest;
  logic        nup;
  logic [15:0] norm_r;
  logic [8:0]  e;

  assign sgn  = x_i[31];
  assign rexp = x_i[30:23];
  assign man  = x_i[22:0];
  assign sig  = {2'b01, man};
  assign e    = {1'b0, rexp} - {1'b0, hfc_pkg::ExpBiasDiff};

  // subnormal path: drop = 126 - rexp, valid range 14..25 (rexp 101..112)
  assign drop  = 5'(8'd126 - rexp);
  assign kept  = sig >> drop;
  assign rmask = (25'd1 << drop) - 25'd1;
  assign rest  = sig & rmask;
  assign halfw = 25'd1 << (drop - 5'd1);
  assign sub_r = kept[10:0] + 11'((rest > halfw) || (rest == halfw && kept[0]));

  assign nkept  = man[22:13];
  assign nrest  = man[12:0];
  assign nup    = nrest[12] && ((nrest[11:0] != '0) || nkept[0]);
  assign norm_r = ({1'b0, e[4:0], 10'd0}) + {6'd0, nkept} + 16'(nup);

  always_comb begin
    priority if (rexp == 8'hff) begin
      h_o = {sgn, 5'h1f, (man[22:13] != '0) ? man[22:13] :
             ((man != '0) ? 10'd1 : 10'd0)};
    end else if (rexp == 8'd0) begin
      h_o = {sgn, 15'd0};
    end else if (rexp >= 8'd143) begin
      h_o = {sgn, 15'h7c00};
    end else if (rexp <= 8'd112) begin
      h_o = (rexp < 8'd101) ? {sgn, 15'd0} : {sgn, 4'd0, sub_r};
    end else begin
      h_o = {sgn, norm_r[14:0]};
    end
  end

endmodule

// ===== sv/hfc_h2f.sv =====
module hfc_h2f (
  input  logic [15:0] h_i,
  output logic [31:0] f_o
);

  logic       sgn;
  logic [4:0] e;
  logic [9:0] man;
  logic [3:0] top;
  logic [9:0] shifted;

  assign sgn = h_i[15];
  assign e   = h_i[14:10];
  assign man = h_i[9:0];

  // find leading one of a subnormal mantissa
  always_comb begin
    top = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) top = 4'(i);
    end
  end

  assign shifted = man << (4'd10 - top);

  always_comb begin
    priority if (e == 5'd0) begin
      f_o = (man == '0) ? {sgn, 31'd0} :
            {sgn, 8'({4'd0, top} + 8'd103), shifted, 13'd0};
    end else if (e == 5'h1f) begin
      f_o = {sgn, 8'hff, man, 13'd0};
    end else begin
      f_o = {sgn, 8'({3'd0, e} + hfc_pkg::ExpBiasDiff), man, 13'd0};
    end
  end

endmodule

// ===== sv/half_float_converter_top.sv =====
// An accepted item passes through an input register, the conversion logic and a
// result register before the done_o strobe.
// Throughput: one item per cycle; busy_o is tied low.
// Reset clears the valid pipeline; data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module half_float_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [31:0] operand_bits_i,
  output logic        done_o,
  output logic [31:0] result_bits_o
);

  hfc_pkg::item_t in_q;
  logic           in_vld_q;
  logic           out_vld_q;
  logic [31:0]    res_q;
  logic [31:0]    res_d;
  logic [15:0]    half_w;
  logic [31:0]    single_w;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q.cmd <= command_i;
      in_q.op  <= operand_bits_i;
    end
    if (in_vld_q) res_q <= res_d;
  end

  hfc_f2h u_f2h (.x_i(in_q.op), .h_o(half_w));
  hfc_h2f u_h2f (.h_i(in_q.op[15:0]), .f_o(single_w));

  assign res_d = (in_q.cmd == hfc_pkg::CmdF16ToF32) ? single_w : {16'd0, half_w};

  assign done_o        = out_vld_q;
  assign result_bits_o = res_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> ##1 done_o) else $error("missing result strobe");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2)) else $error("result without item");
  a_half_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && in_q.cmd == hfc_pkg::CmdF32ToF16) |=> res_q[31:16] == 16'd0)
    else $error("half result upper bits set");

endmodule
